// File: rtl/tgkel_pkg.sv
// Package for the touch gesture and key event latch.
// Holds the event codes, register indexes, reset values and the packed
// payload layouts. No dependencies.
`default_nettype none

package tgkel_pkg;

  // Event codes carried in the action field.
  typedef enum logic [2:0] {
    ACT_TOUCH_DOWN = 3'd0,
    ACT_TOUCH_MOVE = 3'd1,
    ACT_TOUCH_UP   = 3'd2,
    ACT_TICK       = 3'd3,
    ACT_KEY_DOWN   = 3'd4,
    ACT_KEY_UP     = 3'd5
  } action_t;

  // Bit positions in the event flags.
  localparam int unsigned EV_DOWN      = 0;
  localparam int unsigned EV_TAP       = 1;
  localparam int unsigned EV_SWIPE     = 2;
  localparam int unsigned EV_RELEASED  = 3;
  localparam int unsigned EV_LONG      = 4;
  localparam int unsigned EV_HOME_TAP  = 5;
  localparam int unsigned EV_HOME_LONG = 6;

  localparam int unsigned EV_W   = 7;
  localparam int unsigned MASK_W = 8;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned MS_W   = 32;
  localparam int unsigned KEY_W  = 3;
  localparam int unsigned CFG_W  = 16;

  localparam logic [KEY_W-1:0] HOME_KEY = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_SLOP       = 3'd0;
  localparam logic [2:0] REG_SWIPE_MIN  = 3'd1;
  localparam logic [2:0] REG_SWIPE_MAX  = 3'd2;
  localparam logic [2:0] REG_LONG_PRESS = 3'd3;
  localparam logic [2:0] REG_HOME_LONG  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [POS_W-1:0] SLOP_RESET       = 10'd28;
  localparam logic [POS_W-1:0] SWIPE_MIN_RESET  = 10'd60;
  localparam logic [CFG_W-1:0] SWIPE_MAX_RESET  = 16'd700;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd500;
  localparam logic [CFG_W-1:0] HOME_LONG_RESET  = 16'd700;

  // Input payload, last field in the lowest bits.
  typedef struct packed {
    logic             pad;
    logic [MS_W-1:0]  now_ms;
    logic [KEY_W-1:0] key_index;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_x;
  } in_data_t;

  // Result payload, last field in the lowest bits.
  typedef struct packed {
    logic [3:0]        pad;
    logic [POS_W-1:0]  current_y;
    logic [POS_W-1:0]  current_x;
    logic              touch_active;
    logic [MS_W-1:0]   last_duration_ms;
    logic [POS_W-1:0]  end_y;
    logic [POS_W-1:0]  end_x;
    logic [POS_W-1:0]  start_y;
    logic [POS_W-1:0]  start_x;
    logic [MASK_W-1:0] held_mask;
    logic [MASK_W-1:0] released_mask;
    logic [MASK_W-1:0] pressed_mask;
    logic [EV_W-1:0]   event_flags;
  } out_data_t;

endpackage

`default_nettype wire

// File: rtl/touch_gesture_and_key_event_latch.sv
// Top level of the touch gesture and key event latch.
// Uses tgkel_pkg for event codes, register indexes and payload layouts.
// Checked by tgkel_checker, which binds itself to this module.
`default_nettype none

// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   tuser action, tdata position, key, time
// m_*       out        m_tvalid / m_tready   tdata events, masks, points, duration
// cfg_*     in         cfg_valid / cfg_ready cfg_index register, cfg_data value
//
// One event is taken in every clock cycle while results are taken; an event
// passes through the input register and then the result register, with the
// gesture logic between them.
// Reset (rst, synchronous) empties both registers and returns every gesture,
// key and pending flag to zero and the configuration registers to defaults.
// When the result is not taken, the input register fills and then s_tready
// drops; nothing is lost and transfers resume in the cycle m_tready returns.
// Configuration writes are always taken (cfg_ready is tied high).

module touch_gesture_and_key_event_latch #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input events.
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // tuser: action [2:0]
  input  wire logic [2:0]  s_tuser,
  // tdata: pos_x [9:0], pos_y [19:10], key_index [22:20], now_ms [54:23], zero [55]
  input  wire logic [55:0] s_tdata,
  // Results.
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  // tdata: event_flags [6:0], pressed_mask [14:7], released_mask [22:15],
  // held_mask [30:23], start_x [40:31], start_y [50:41], end_x [60:51],
  // end_y [70:61], last_duration_ms [102:71], touch_active [103],
  // current_x [113:104], current_y [123:114], zero [127:124]
  output      logic [127:0] m_tdata,
  // Configuration writes.
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import tgkel_pkg::*;

  localparam int unsigned KEY_CMP_W = 5;

  // Configuration registers.
  logic [POS_W-1:0] slop_distance;
  logic [POS_W-1:0] swipe_min_distance;
  logic [CFG_W-1:0] swipe_max_ms;
  logic [CFG_W-1:0] long_press_ms;
  logic [CFG_W-1:0] home_long_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slop_distance      <= SLOP_RESET;
      swipe_min_distance <= SWIPE_MIN_RESET;
      swipe_max_ms       <= SWIPE_MAX_RESET;
      long_press_ms      <= LONG_PRESS_RESET;
      home_long_ms       <= HOME_LONG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SLOP:       slop_distance      <= cfg_data[POS_W-1:0];
        REG_SWIPE_MIN:  swipe_min_distance <= cfg_data[POS_W-1:0];
        REG_SWIPE_MAX:  swipe_max_ms       <= cfg_data;
        REG_LONG_PRESS: long_press_ms      <= cfg_data;
        REG_HOME_LONG:  home_long_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. It advances whenever the result register is free or
  // being emptied in this cycle.
  logic       in_v;
  logic [2:0] in_act;
  in_data_t   in_d;
  logic       out_free;
  logic       adv;

  assign out_free = !m_tvalid || m_tready;
  assign adv      = in_v && out_free;
  assign s_tready = !in_v || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_v <= 1'b1;
    end else if (adv) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_act <= s_tuser;
      in_d   <= in_data_t'(s_tdata);
    end
  end

  // Gesture state.
  logic              touching, touching_next;
  logic [POS_W-1:0]  down_point_x, down_point_x_next;
  logic [POS_W-1:0]  down_point_y, down_point_y_next;
  logic [POS_W-1:0]  latest_x, latest_x_next;
  logic [POS_W-1:0]  latest_y, latest_y_next;
  logic [POS_W-1:0]  lift_point_x, lift_point_x_next;
  logic [POS_W-1:0]  lift_point_y, lift_point_y_next;
  logic [MS_W-1:0]   down_time, down_time_next;
  logic [MS_W-1:0]   touch_length, touch_length_next;
  logic              moved_too_far, moved_too_far_next;
  logic              long_fired, long_fired_next;
  logic              suppressed, suppressed_next;
  logic              home_held, home_held_next;
  logic [MS_W-1:0]   home_down_time, home_down_time_next;
  logic              home_long_done, home_long_done_next;
  logic [MASK_W-1:0] buttons_held, buttons_held_next;
  logic [MASK_W-1:0] pending_pressed, pending_pressed_next;
  logic [MASK_W-1:0] pending_released, pending_released_next;
  logic [EV_W-1:0]   pending_events, pending_events_next;
  logic [EV_W-1:0]   shown_events, shown_events_next;
  logic [MASK_W-1:0] shown_pressed, shown_pressed_next;
  logic [MASK_W-1:0] shown_released, shown_released_next;

  // Distances from the press point and elapsed times.
  logic [POS_W-1:0]  dx, dy, big;
  logic [MS_W-1:0]   touch_dur, home_dur;
  logic              key_is_button;
  logic [MASK_W-1:0] key_bit;

  always_comb begin
    dx        = (in_d.pos_x > down_point_x) ? in_d.pos_x - down_point_x
                                            : down_point_x - in_d.pos_x;
    dy        = (in_d.pos_y > down_point_y) ? in_d.pos_y - down_point_y
                                            : down_point_y - in_d.pos_y;
    big       = (dx > dy) ? dx : dy;
    touch_dur = in_d.now_ms - down_time;
    home_dur  = in_d.now_ms - home_down_time;
    key_is_button = (in_d.key_index != HOME_KEY) &&
                    ({{(KEY_CMP_W-KEY_W){1'b0}}, in_d.key_index} <
                     KEY_CMP_W'(NUM_BUTTONS));
    key_bit   = MASK_W'(1) << in_d.key_index;
  end

  always_comb begin
    touching_next         = touching;
    down_point_x_next     = down_point_x;
    down_point_y_next     = down_point_y;
    latest_x_next         = latest_x;
    latest_y_next         = latest_y;
    lift_point_x_next     = lift_point_x;
    lift_point_y_next     = lift_point_y;
    down_time_next        = down_time;
    touch_length_next     = touch_length;
    moved_too_far_next    = moved_too_far;
    long_fired_next       = long_fired;
    suppressed_next       = suppressed;
    home_held_next        = home_held;
    home_down_time_next   = home_down_time;
    home_long_done_next   = home_long_done;
    buttons_held_next     = buttons_held;
    pending_pressed_next  = pending_pressed;
    pending_released_next = pending_released;
    pending_events_next   = pending_events;
    shown_events_next     = shown_events;
    shown_pressed_next    = shown_pressed;
    shown_released_next   = shown_released;

    case (action_t'(in_act))
      ACT_TOUCH_DOWN: begin
        // A second press restarts the touch but keeps the suppression.
        touching_next       = 1'b1;
        down_point_x_next   = in_d.pos_x;
        down_point_y_next   = in_d.pos_y;
        latest_x_next       = in_d.pos_x;
        latest_y_next       = in_d.pos_y;
        down_time_next      = in_d.now_ms;
        moved_too_far_next  = 1'b0;
        long_fired_next     = 1'b0;
        pending_events_next[EV_DOWN] = 1'b1;
      end
      ACT_TOUCH_MOVE: begin
        latest_x_next = in_d.pos_x;
        latest_y_next = in_d.pos_y;
        if (touching && (dx > slop_distance || dy > slop_distance)) begin
          moved_too_far_next = 1'b1;
        end
      end
      ACT_TOUCH_UP: begin
        if (touching) begin
          touching_next     = 1'b0;
          lift_point_x_next = in_d.pos_x;
          lift_point_y_next = in_d.pos_y;
          touch_length_next = touch_dur;
          pending_events_next[EV_RELEASED] = 1'b1;
          if (!suppressed && !long_fired) begin
            if (big >= swipe_min_distance) begin
              // Long travel counts only when it was quick enough.
              if (touch_dur <= {{(MS_W-CFG_W){1'b0}}, swipe_max_ms}) begin
                pending_events_next[EV_SWIPE] = 1'b1;
              end
            end else begin
              pending_events_next[EV_TAP] = 1'b1;
            end
          end
        end
      end
      ACT_TICK: begin
        shown_pressed_next    = pending_pressed;
        shown_released_next   = pending_released;
        shown_events_next     = pending_events;
        pending_pressed_next  = '0;
        pending_released_next = '0;
        pending_events_next   = '0;
        if (touching && !moved_too_far && !long_fired && !suppressed &&
            touch_dur >= {{(MS_W-CFG_W){1'b0}}, long_press_ms}) begin
          long_fired_next = 1'b1;
          suppressed_next = 1'b1;
          pending_events_next[EV_LONG] = 1'b1;
        end
        if (home_held && !home_long_done &&
            home_dur >= {{(MS_W-CFG_W){1'b0}}, home_long_ms}) begin
          home_long_done_next = 1'b1;
          pending_events_next[EV_HOME_LONG] = 1'b1;
        end
        if (!touching) begin
          suppressed_next = 1'b0;
          long_fired_next = 1'b0;
        end
      end
      ACT_KEY_DOWN: begin
        if (in_d.key_index == HOME_KEY) begin
          home_held_next      = 1'b1;
          home_down_time_next = in_d.now_ms;
          home_long_done_next = 1'b0;
        end else if (key_is_button) begin
          buttons_held_next    = buttons_held | key_bit;
          pending_pressed_next = pending_pressed | key_bit;
        end
      end
      ACT_KEY_UP: begin
        if (in_d.key_index == HOME_KEY) begin
          if (home_held) begin
            home_held_next = 1'b0;
            if (!home_long_done) begin
              pending_events_next[EV_HOME_TAP] = 1'b1;
            end
          end
        end else if (key_is_button) begin
          buttons_held_next     = buttons_held & ~key_bit;
          pending_released_next = pending_released | key_bit;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touching         <= 1'b0;
      down_point_x     <= '0;
      down_point_y     <= '0;
      latest_x         <= '0;
      latest_y         <= '0;
      lift_point_x     <= '0;
      lift_point_y     <= '0;
      down_time        <= '0;
      touch_length     <= '0;
      moved_too_far    <= 1'b0;
      long_fired       <= 1'b0;
      suppressed       <= 1'b0;
      home_held        <= 1'b0;
      home_down_time   <= '0;
      home_long_done   <= 1'b0;
      buttons_held     <= '0;
      pending_pressed  <= '0;
      pending_released <= '0;
      pending_events   <= '0;
      shown_events     <= '0;
      shown_pressed    <= '0;
      shown_released   <= '0;
    end else if (adv) begin
      touching         <= touching_next;
      down_point_x     <= down_point_x_next;
      down_point_y     <= down_point_y_next;
      latest_x         <= latest_x_next;
      latest_y         <= latest_y_next;
      lift_point_x     <= lift_point_x_next;
      lift_point_y     <= lift_point_y_next;
      down_time        <= down_time_next;
      touch_length     <= touch_length_next;
      moved_too_far    <= moved_too_far_next;
      long_fired       <= long_fired_next;
      suppressed       <= suppressed_next;
      home_held        <= home_held_next;
      home_down_time   <= home_down_time_next;
      home_long_done   <= home_long_done_next;
      buttons_held     <= buttons_held_next;
      pending_pressed  <= pending_pressed_next;
      pending_released <= pending_released_next;
      pending_events   <= pending_events_next;
      shown_events     <= shown_events_next;
      shown_pressed    <= shown_pressed_next;
      shown_released   <= shown_released_next;
    end
  end

  // Result register: the state as it stands after the event.
  out_data_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.pad              <= '0;
      res.event_flags      <= shown_events_next;
      res.pressed_mask     <= shown_pressed_next;
      res.released_mask    <= shown_released_next;
      res.held_mask        <= buttons_held_next;
      res.start_x          <= down_point_x_next;
      res.start_y          <= down_point_y_next;
      res.end_x            <= lift_point_x_next;
      res.end_y            <= lift_point_y_next;
      res.last_duration_ms <= touch_length_next;
      res.touch_active     <= touching_next;
      res.current_x        <= latest_x_next;
      res.current_y        <= latest_y_next;
    end
  end

  assign m_tdata = res;

endmodule

`default_nettype wire

// File: rtl/tgkel_checker.sv
// Port-level checker for the touch gesture and key event latch.
// Depends on nothing but the top level's ports; bound to
// touch_gesture_and_key_event_latch at the end of this file.
`default_nettype none

module tgkel_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [127:0] m_tdata
);

  // A result that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or vanished while stalled");

  // A new result only follows an input transfer that went through the input register.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a preceding input transfer");

  // A tap or a swipe is always published together with the release that
  // classified it.
  a_tap_swipe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[1] || m_tdata[2]) || m_tdata[3])
    else $error("tap or swipe published without a release");

  // The home key is never part of the button masks.
  a_home_not_button: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[14] && !m_tdata[22] && !m_tdata[30])
    else $error("home key bit set in a button mask");

endmodule

bind touch_gesture_and_key_event_latch tgkel_checker u_tgkel_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
